@@ src/tme_pkg.sv @@
// Shared types and constants for the tape machine execute stage.
// Used by tape_machine_execute; depends on nothing.
`timescale 1ns / 1ps

package tme_pkg;

  // Sizes of the tape and the loop return stack.
  localparam int TAPE_CELLS  = 4096;
  localparam int STACK_DEPTH = 64;

  // Derived widths.
  localparam int TAPE_AW  = $clog2(TAPE_CELLS);
  localparam int STACK_AW = $clog2(STACK_DEPTH);
  localparam int COUNT_W  = STACK_AW + 1;

  // Fixed widths of the word fields.
  localparam int OPCODE_W = 3;
  localparam int ADDR_W   = 12;
  localparam int NEXT_W   = 13;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;

  // Landmarks on the tape and the stack.
  localparam logic [TAPE_AW-1:0] TAPE_MID  = TAPE_AW'(TAPE_CELLS / 2);
  localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_CELLS - 1);
  localparam logic [COUNT_W-1:0] STACK_FULL = COUNT_W'(STACK_DEPTH);

  // Instruction set.
  typedef enum logic [OPCODE_W-1:0] {
    OP_PRINT = 3'd0,
    OP_READ  = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_INC   = 3'd4,
    OP_DEC   = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } opcode_t;

  // Sticky run status.
  typedef enum logic [STATUS_W-1:0] {
    ST_RUN   = 3'd0,
    ST_EOF   = 3'd1,
    ST_OVER  = 3'd2,
    ST_UNDER = 3'd3,
    ST_EDGE  = 3'd4
  } status_t;

endpackage

@@ src/tape_machine_execute.sv @@
// Execute stage of the eight-instruction tape machine.
// A word is held in the execute stage registers, then its result in the output register.
// Throughput: one instruction per cycle unless stalled; tape and stack read on accept.
// Tape read-modify-write and stack push/pop are forwarded to the following word.
// Reset: position 2048, empty stack, running; then all 4096 cells cleared, in_stall high.
// The loop stack memory is not cleared; only pushed entries are ever used.
`timescale 1ns / 1ps

module tape_machine_execute
  import tme_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Instruction words in.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [ADDR_W-1:0]   in_address,
  input  logic [ADDR_W-1:0]   in_match_address,
  input  logic [BYTE_W-1:0]   in_in_byte,
  input  logic                in_in_end,
  // Result words out.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NEXT_W-1:0]   out_next_address,
  output logic                out_out_valid,
  output logic [BYTE_W-1:0]   out_out_byte,
  output logic [STATUS_W-1:0] out_status
);

  // Clear sweep.
  logic               clr_active_r;
  logic [TAPE_AW-1:0] clr_addr_r;

  // Machine state.
  logic [TAPE_AW-1:0] pos_r, pos_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  status_t            stop_r, stop_nxt;

  // Execute stage registers.
  logic               s1_valid_r;
  opcode_t            s1_opcode_r;
  logic [ADDR_W-1:0]  s1_address_r;
  logic [ADDR_W-1:0]  s1_match_r;
  logic [BYTE_W-1:0]  s1_byte_r;
  logic               s1_end_r;

  // Forwarding registers.
  logic               tape_hit_r, tape_hit_nxt;
  logic [BYTE_W-1:0]  tape_fwd_r;
  logic               stk_hit_r, stk_hit_nxt;
  logic [ADDR_W-1:0]  stk_fwd_r;

  // Output register.
  logic               out_valid_r;
  logic [NEXT_W-1:0]  out_next_r;
  logic               out_flag_r;
  logic [BYTE_W-1:0]  out_byte_r;
  status_t            out_status_r;

  // Handshake.
  logic               in_accept;
  logic               s1_fire;

  // Memory ports.
  logic               tape_we;
  logic [TAPE_AW-1:0] tape_waddr;
  logic [BYTE_W-1:0]  tape_wdata;
  logic [TAPE_AW-1:0] tape_raddr;
  logic [BYTE_W-1:0]  tape_rdata;
  logic               stk_we;
  logic [STACK_AW-1:0] stk_waddr;
  logic [STACK_AW-1:0] stk_raddr;
  logic [ADDR_W-1:0]  stk_rdata;
  logic [COUNT_W-1:0] count_dec;

  // Execute results.
  logic [BYTE_W-1:0]  cur_cell;
  logic [ADDR_W-1:0]  top;
  logic [TAPE_AW-1:0] exe_pos;
  logic [COUNT_W-1:0] exe_count;
  status_t            exe_stop;
  logic [NEXT_W-1:0]  exe_next;
  logic               exe_flag;
  logic [BYTE_W-1:0]  exe_byte;
  logic               exe_tape_we;
  logic [BYTE_W-1:0]  exe_tape_wdata;
  logic               exe_push;

  // Handshake: the execute stage moves on when the output register is free or drains.
  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = clr_active_r || (s1_valid_r && !s1_fire);
  assign in_accept = in_valid && !in_stall;

  // Current cell and stack top, with the previous word's write forwarded.
  assign cur_cell = tape_hit_r ? tape_fwd_r : tape_rdata;
  assign top      = stk_hit_r ? stk_fwd_r : stk_rdata;

  // Execute one instruction against the state.
  always_comb begin
    exe_pos        = pos_r;
    exe_count      = count_r;
    exe_stop       = stop_r;
    exe_next       = NEXT_W'(s1_address_r) + NEXT_W'(1);
    exe_flag       = 1'b0;
    exe_byte       = '0;
    exe_tape_we    = 1'b0;
    exe_tape_wdata = s1_byte_r;
    exe_push       = 1'b0;
    if (stop_r != ST_RUN) begin
      exe_next = NEXT_W'(s1_address_r);
    end else begin
      case (s1_opcode_r)
        OP_PRINT: begin
          exe_flag = 1'b1;
          exe_byte = cur_cell;
        end
        OP_READ: begin
          if (s1_end_r) begin
            exe_stop = ST_EOF;
            exe_next = NEXT_W'(s1_address_r);
          end else begin
            exe_tape_we = 1'b1;
          end
        end
        OP_LEFT: begin
          if (pos_r == '0) begin
            exe_stop = ST_EDGE;
            exe_next = NEXT_W'(s1_address_r);
          end else begin
            exe_pos = pos_r - TAPE_AW'(1);
          end
        end
        OP_RIGHT: begin
          if (pos_r == TAPE_LAST) begin
            exe_stop = ST_EDGE;
            exe_next = NEXT_W'(s1_address_r);
          end else begin
            exe_pos = pos_r + TAPE_AW'(1);
          end
        end
        OP_INC: begin
          exe_tape_we    = 1'b1;
          exe_tape_wdata = cur_cell + BYTE_W'(1);
        end
        OP_DEC: begin
          exe_tape_we    = 1'b1;
          exe_tape_wdata = cur_cell - BYTE_W'(1);
        end
        OP_OPEN: begin
          if (cur_cell == '0) begin
            exe_next = NEXT_W'(s1_match_r) + NEXT_W'(1);
          end else if (count_r == STACK_FULL) begin
            exe_stop = ST_OVER;
            exe_next = NEXT_W'(s1_address_r);
          end else begin
            exe_push  = 1'b1;
            exe_count = count_r + COUNT_W'(1);
          end
        end
        OP_CLOSE: begin
          if (count_r == '0) begin
            exe_stop = ST_UNDER;
            exe_next = NEXT_W'(s1_address_r);
          end else begin
            exe_count = count_r - COUNT_W'(1);
            exe_next  = NEXT_W'(top);
          end
        end
        default: begin
          exe_next = NEXT_W'(s1_address_r);
        end
      endcase
    end
  end

  // State after this cycle; the next word reads the tape and stack with it.
  assign pos_nxt   = s1_fire ? exe_pos : pos_r;
  assign count_nxt = s1_fire ? exe_count : count_r;
  assign stop_nxt  = s1_fire ? exe_stop : stop_r;

  // Tape port: the clear sweep owns it after reset.
  assign tape_we    = clr_active_r || (s1_fire && exe_tape_we);
  assign tape_waddr = clr_active_r ? clr_addr_r : pos_r;
  assign tape_wdata = clr_active_r ? '0 : exe_tape_wdata;
  assign tape_raddr = pos_nxt;

  // Stack port: push at the count, read the new top for the next word.
  assign stk_we    = s1_fire && exe_push;
  assign stk_waddr = count_r[STACK_AW-1:0];
  assign count_dec = count_nxt - COUNT_W'(1);
  assign stk_raddr = count_dec[STACK_AW-1:0];

  // A write landing on the address being read is forwarded.
  assign tape_hit_nxt = tape_we && (tape_waddr == tape_raddr);
  assign stk_hit_nxt  = stk_we && (stk_waddr == stk_raddr);

  tme_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (TAPE_CELLS)
  ) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .re    (in_accept),
    .raddr (tape_raddr),
    .rdata (tape_rdata)
  );

  tme_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (s1_address_r),
    .re    (in_accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // Control state and the clear sweep.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      pos_r        <= TAPE_MID;
      count_r      <= '0;
      stop_r       <= ST_RUN;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      tape_hit_r   <= 1'b0;
      stk_hit_r    <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + TAPE_AW'(1);
        if (clr_addr_r == TAPE_LAST) begin
          clr_active_r <= 1'b0;
        end
      end
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      stop_r  <= stop_nxt;
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        tape_hit_r <= tape_hit_nxt;
        stk_hit_r  <= stk_hit_nxt;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Word payload and forwarded data.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode_r  <= opcode_t'(in_opcode);
      s1_address_r <= in_address;
      s1_match_r   <= in_match_address;
      s1_byte_r    <= in_in_byte;
      s1_end_r     <= in_in_end;
      tape_fwd_r   <= tape_wdata;
      stk_fwd_r    <= s1_address_r;
    end
    if (s1_fire) begin
      out_next_r   <= exe_next;
      out_flag_r   <= exe_flag;
      out_byte_r   <= exe_byte;
      out_status_r <= exe_stop;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_next_address = out_next_r;
  assign out_out_valid    = out_flag_r;
  assign out_out_byte     = out_byte_r;
  assign out_status       = out_status_r;

  // The stack count never passes the stack depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= STACK_FULL)
    else $error("loop stack count beyond depth");

  // A fault is sticky.
  assert property (@(posedge clk) disable iff (!rst_n) (stop_r != ST_RUN) |=> $stable(stop_r))
    else $error("stop code changed after a fault");

  // Once stopped, neither the position nor the stack moves.
  assert property (@(posedge clk) disable iff (!rst_n)
    (stop_r != ST_RUN) |=> ($stable(pos_r) && $stable(count_r)))
    else $error("state changed while stopped");

  // No instruction is in flight while the tape is being cleared.
  assert property (@(posedge clk) disable iff (!rst_n) clr_active_r |-> !s1_valid_r)
    else $error("instruction executed during tape clear");

  // The stack is written only while running.
  assert property (@(posedge clk) disable iff (!rst_n) stk_we |-> (stop_r == ST_RUN))
    else $error("stack push while stopped");

endmodule

@@ src/tme_ram.sv @@
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is enabled; no dependencies.
`timescale 1ns / 1ps

module tme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, and a read port that returns the old data on a collision.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
